/* hdl/irpw_pkg.sv */
package irpw_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int TIMER_W   = 16;
  localparam int LINES_W   = 9;
  localparam int OP_W      = 2;
  localparam int STATE_W   = 3;

  localparam logic [TIMER_W-1:0] GAP_RESET = TIMER_W'(100);
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_READ   = 2'd1,
    OP_RESUME = 2'd2
  } op_t;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE     = 3'd0,
    ST_MARK     = 3'd1,
    ST_SPACE    = 3'd2,
    ST_STOP     = 3'd3,
    ST_OVERFLOW = 3'd4
  } rx_state_t;

endpackage

/* hdl/ir_pulse_width_recorder.sv */
// The result of an input transfer is held in the output register from the next cycle on.
// Throughput: one item per cycle while the output register is drained; the state update and the duration buffer port
// (one write, one registered read) both complete within the accepting cycle.
// Input is taken whenever the output register is empty or being drained.
// Reset (rst, synchronous): state idle, timer and count zero, gap limit 100,
// output empty. The duration buffer is not cleared.
module ir_pulse_width_recorder (
  input  logic        clk,
  input  logic        rst,
  input  logic        gap_limit_we,
  input  logic [15:0] gap_limit_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], sensor_lines[10:2], read_index[17:11], zero fill
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // receive_state[2:0], code_ready[3], overflow_seen[4], entries_stored[12:5],
  // wrote_entry[13], read_value[29:14], zero fill
  output logic [31:0] m_axis_tdata
);

  localparam int AW = irpw_pkg::ADDR_W;
  localparam int CW = irpw_pkg::CNT_W;
  localparam int TW = irpw_pkg::TIMER_W;

  logic [TW-1:0] gap_limit;

  irpw_pkg::rx_state_t rx_state, rx_state_next;
  logic [TW-1:0] tick_timer, tick_timer_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic          overflow_flag, overflow_flag_next;

  logic [TW-1:0] duration_store [irpw_pkg::BUF_DEPTH];
  logic [TW-1:0] rd_data;
  logic          rd_sel;

  logic                      res_valid;
  irpw_pkg::rx_state_t       res_state;
  logic                      res_overflow;
  logic [CW-1:0]             res_count;
  logic                      res_wrote;

  logic                         accept;
  logic [irpw_pkg::OP_W-1:0]    in_op;
  logic [irpw_pkg::LINES_W-1:0] in_lines;
  logic [AW-1:0]                in_index;
  logic                         mark;
  logic [TW-1:0]                timer_inc;
  logic                         wr_en;

  assign in_op    = s_axis_tdata[1:0];
  assign in_lines = s_axis_tdata[10:2];
  assign in_index = s_axis_tdata[17:11];

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign mark      = (in_lines != '1);
  assign timer_inc = (tick_timer != irpw_pkg::TIMER_MAX) ? tick_timer + TW'(1) : tick_timer;

  always_comb begin
    irpw_pkg::rx_state_t st;
    st                 = rx_state;
    rx_state_next      = rx_state;
    tick_timer_next    = tick_timer;
    entry_count_next   = entry_count;
    overflow_flag_next = overflow_flag;
    wr_en              = 1'b0;
    case (in_op)
      irpw_pkg::OP_TICK: begin
        tick_timer_next = timer_inc;
        st = (entry_count >= CW'(irpw_pkg::BUF_DEPTH)) ? irpw_pkg::ST_OVERFLOW : rx_state;
        rx_state_next = st;
        // a full buffer always diverts to overflow first, so every record below fits
        unique case (st)
          irpw_pkg::ST_IDLE: begin
            if (mark) begin
              tick_timer_next = '0;
              if (timer_inc >= gap_limit) begin
                overflow_flag_next = 1'b0;
                entry_count_next   = CW'(1);
                wr_en              = 1'b1;
                rx_state_next      = irpw_pkg::ST_MARK;
              end
            end
          end
          irpw_pkg::ST_MARK: begin
            if (!mark) begin
              wr_en            = 1'b1;
              entry_count_next = entry_count + CW'(1);
              tick_timer_next  = '0;
              rx_state_next    = irpw_pkg::ST_SPACE;
            end
          end
          irpw_pkg::ST_SPACE: begin
            if (mark) begin
              wr_en            = 1'b1;
              entry_count_next = entry_count + CW'(1);
              tick_timer_next  = '0;
              rx_state_next    = irpw_pkg::ST_MARK;
            end else if (timer_inc > gap_limit) begin
              rx_state_next = irpw_pkg::ST_STOP;
            end
          end
          irpw_pkg::ST_STOP: begin
            if (mark) begin
              tick_timer_next = '0;
            end
          end
          default: begin
            overflow_flag_next = 1'b1;
            rx_state_next      = irpw_pkg::ST_STOP;
          end
        endcase
      end
      irpw_pkg::OP_RESUME: begin
        rx_state_next    = irpw_pkg::ST_IDLE;
        entry_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= irpw_pkg::GAP_RESET;
    end else if (gap_limit_we) begin
      gap_limit <= gap_limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_state      <= irpw_pkg::ST_IDLE;
      tick_timer    <= '0;
      entry_count   <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      rx_state      <= rx_state_next;
      tick_timer    <= tick_timer_next;
      entry_count   <= entry_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  // idle start records at entry zero since the count restarts there
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      if (rx_state_next == irpw_pkg::ST_MARK && entry_count_next == CW'(1)
          && (rx_state == irpw_pkg::ST_IDLE)) begin
        duration_store[AW'(0)] <= timer_inc;
      end else begin
        duration_store[entry_count[AW-1:0]] <= timer_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= duration_store[in_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_state    <= rx_state_next;
      res_overflow <= overflow_flag_next;
      res_count    <= entry_count_next;
      res_wrote    <= wr_en;
      rd_sel       <= (in_op == irpw_pkg::OP_READ);
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {2'b00,
                          rd_sel ? rd_data : TW'(0),
                          res_wrote,
                          res_count,
                          res_overflow,
                          (res_state == irpw_pkg::ST_STOP),
                          res_state};

endmodule

/* hdl/irpw_checker.sv */
module irpw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [2:0] out_state;
  assign out_state = m_axis_tdata[2:0];

  // a transfer in always shows up as a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_ready_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3] == (out_state == irpw_pkg::ST_STOP)))
    else $error("code_ready disagrees with receive_state");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != irpw_pkg::OP_READ)
      |=> (m_axis_tdata[29:14] == 16'd0))
    else $error("read_value nonzero for a non-read item");

  a_wrote_state: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[13])
      |-> (out_state == irpw_pkg::ST_MARK || out_state == irpw_pkg::ST_SPACE))
    else $error("duration recorded outside mark or space");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind ir_pulse_width_recorder irpw_checker u_irpw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_ir_pulse_width_recorder.sv */
module tb_ir_pulse_width_recorder;
  timeunit 1ns;
  timeprecision 1ps;

  import irpw_pkg::*;

  localparam logic [OP_W-1:0]    OP_NOP      = 2'd3;
  localparam logic [LINES_W-1:0] LINES_SPACE = '1;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 950;

  typedef struct {
    rx_state_t         st;
    logic              ready;
    logic              ovf;
    logic [7:0]        stored;
    logic              wrote;
    logic [TIMER_W-1:0] rval;
  } rx_status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  gap_limit_we = 1'b0;
  logic [15:0]           gap_limit_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // receiver status mirror
  rx_state_t          mdl_state;
  logic [TIMER_W-1:0] mdl_timer;
  int                 mdl_count;
  logic               mdl_ovf;
  logic [15:0]        mdl_gap;
  logic [TIMER_W-1:0] mdl_store [BUF_DEPTH];
  bit                 mdl_written [BUF_DEPTH];

  rx_status_t status_q[$];

  int src_idle_pct = 25;
  int snk_idle_pct = 25;
  int hold_left = 0;
  int sent_items = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  ir_pulse_width_recorder i_dut (
    .clk             (clk),
    .rst             (rst),
    .gap_limit_we    (gap_limit_we),
    .gap_limit_wdata (gap_limit_wdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata)
  );

  always #10 clk = ~clk;

  function automatic bit store_duration();
    if (mdl_count >= BUF_DEPTH) return 1'b0;
    mdl_store[mdl_count] = mdl_timer;
    mdl_written[mdl_count] = 1'b1;
    mdl_count++;
    return 1'b1;
  endfunction

  function automatic rx_status_t predict_status(logic [IN_DATA_W-1:0] d);
    rx_status_t         r;
    logic [OP_W-1:0]    op;
    logic [LINES_W-1:0] lines;
    logic [ADDR_W-1:0]  idx;
    bit                 is_mark;
    op = d[1:0];
    lines = d[10:2];
    idx = d[17:11];
    r.wrote = 1'b0;
    r.rval = '0;
    case (op)
      OP_TICK: begin
        is_mark = (lines != LINES_SPACE);
        if (mdl_timer != TIMER_MAX) mdl_timer++;
        if (mdl_count >= BUF_DEPTH) mdl_state = ST_OVERFLOW;
        case (mdl_state)
          ST_IDLE: begin
            if (is_mark) begin
              if (mdl_timer < mdl_gap) begin
                mdl_timer = '0;
              end else begin
                mdl_ovf = 1'b0;
                mdl_count = 0;
                r.wrote = store_duration();
                mdl_timer = '0;
                mdl_state = ST_MARK;
              end
            end
          end
          ST_MARK: begin
            if (!is_mark) begin
              r.wrote = store_duration();
              mdl_timer = '0;
              mdl_state = ST_SPACE;
            end
          end
          ST_SPACE: begin
            if (is_mark) begin
              r.wrote = store_duration();
              mdl_timer = '0;
              mdl_state = ST_MARK;
            end else if (mdl_timer > mdl_gap) begin
              mdl_state = ST_STOP;
            end
          end
          ST_STOP: begin
            if (is_mark) mdl_timer = '0;
          end
          default: begin
            mdl_ovf = 1'b1;
            mdl_state = ST_STOP;
          end
        endcase
      end
      OP_READ: r.rval = mdl_store[idx];
      OP_RESUME: begin
        mdl_state = ST_IDLE;
        mdl_count = 0;
      end
      default: ;
    endcase
    r.st = mdl_state;
    r.ready = (mdl_state == ST_STOP);
    r.ovf = mdl_ovf;
    r.stored = mdl_count[7:0];
    return r;
  endfunction

  function automatic void flag_mismatch(string what, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
  endfunction

  function automatic void cmp_field(string what, longint exp_v, longint act_v);
    if (exp_v != act_v) flag_mismatch(what, exp_v, act_v);
  endfunction

  function automatic void check_status(logic [OUT_DATA_W-1:0] d);
    rx_status_t e;
    if (status_q.size() == 0) begin
      flag_mismatch("result with nothing pending, tdata", 0, d);
      return;
    end
    e = status_q.pop_front();
    cmp_field("receive_state", e.st, d[2:0]);
    cmp_field("code_ready", e.ready, d[3]);
    cmp_field("overflow_seen", e.ovf, d[4]);
    cmp_field("entries_stored", e.stored, d[12:5]);
    cmp_field("wrote_entry", e.wrote, d[13]);
    cmp_field("read_value", e.rval, d[29:14]);
  endfunction

  // Check results before predicting, then track the register write and the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      mdl_state = ST_IDLE;
      mdl_timer = '0;
      mdl_count = 0;
      mdl_ovf = 1'b0;
      mdl_gap = GAP_RESET;
      stall_cycles = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_status(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) status_q.push_back(predict_status(s_axis_tdata));
      if (gap_limit_we) mdl_gap = gap_limit_wdata;
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_ir_pulse_width_recorder NOT OK");
        $finish;
      end
    end
  end

  // Receiver side: a pending hold-off wins over the random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [LINES_W-1:0] lines,
                           logic [ADDR_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_W - ADDR_W - LINES_W - OP_W){1'b0}}, idx, lines, op};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic [LINES_W-1:0] mark_lines();
    logic [LINES_W-1:0] v;
    v = LINES_W'($urandom);
    if (v == LINES_SPACE) v[$urandom_range(LINES_W-1)] = 1'b0;
    return v;
  endfunction

  task automatic send_tick(logic [LINES_W-1:0] lines);
    send_item(OP_TICK, lines, ADDR_W'($urandom));
  endtask

  // Read back a random entry that holds a duration; fall back to a no-op.
  task automatic send_read_any();
    int idx;
    int tries;
    idx = $urandom_range(BUF_DEPTH-1);
    for (tries = 0; tries < BUF_DEPTH && !mdl_written[idx]; tries++)
      idx = (idx + 1) % BUF_DEPTH;
    if (mdl_written[idx])
      send_item(OP_READ, LINES_W'($urandom), ADDR_W'(idx));
    else
      send_item(OP_NOP, LINES_W'($urandom), ADDR_W'($urandom));
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_tick(LINES_W'($urandom));
      1: send_read_any();
      2: send_item(OP_RESUME, LINES_W'($urandom), ADDR_W'($urandom));
      default: send_item(OP_NOP, LINES_W'($urandom), ADDR_W'($urandom));
    endcase
  endtask

  // Drop valid, drain the pipe, pause, then write the register.
  task automatic set_gap(logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    gap_limit_we <= 1'b1;
    gap_limit_wdata <= v;
    @(negedge clk);
    gap_limit_we <= 1'b0;
  endtask

  // One code: lead-in gap, mark/space pairs under the gap, closing gap, up to 3 reads.
  task automatic send_code(int pairs);
    int space_max;
    space_max = (mdl_gap + 1 < 5) ? mdl_gap + 1 : 5;
    repeat ($urandom_range(mdl_gap, mdl_gap + 3)) send_tick(LINES_SPACE);
    repeat (pairs) begin
      repeat ($urandom_range(1, 4)) send_tick(mark_lines());
      repeat ($urandom_range(1, space_max)) send_tick(LINES_SPACE);
      if ($urandom_range(19) == 0) send_noise();
    end
    repeat ($urandom_range(mdl_gap + 2, mdl_gap + 4)) send_tick(LINES_SPACE);
    repeat ($urandom_range(0, 3)) send_read_any();
  endtask

  task automatic test_directed_sequence();
    set_gap(16'd3);
    send_item(OP_NOP, LINES_W'($urandom), ADDR_W'($urandom));
    // mark arriving before the gap has elapsed only restarts the timer
    send_tick('0);
    repeat (3) send_tick(LINES_SPACE);
    for (int b = 0; b < LINES_W; b++) send_tick(~(LINES_W'(1) << b));
    repeat (5) send_tick(LINES_SPACE);
    send_tick(9'h0FF);
    send_item(OP_READ, LINES_SPACE, 7'd0);
    send_item(OP_READ, '0, 7'd1);
    send_item(OP_RESUME, LINES_W'($urandom), ADDR_W'($urandom));
    send_item(OP_NOP, LINES_W'($urandom), ADDR_W'($urandom));
  endtask

  task automatic test_buffer_overflow();
    set_gap(16'd2);
    send_item(OP_RESUME, LINES_W'($urandom), ADDR_W'($urandom));
    repeat (3) send_tick(LINES_SPACE);
    repeat (80) begin
      repeat ($urandom_range(1, 3)) send_tick(mark_lines());
      repeat ($urandom_range(1, 3)) send_tick(LINES_SPACE);
    end
    for (int i = 0; i < BUF_DEPTH; i++)
      send_item(OP_READ, LINES_W'($urandom), ADDR_W'(i));
    send_item(OP_RESUME, LINES_W'($urandom), ADDR_W'($urandom));
    send_code(3);
  endtask

  task automatic test_output_backpressure();
    set_gap(16'd1);
    hold_left = 300;
    send_item(OP_RESUME, LINES_W'($urandom), ADDR_W'($urandom));
    send_code(10);
  endtask

  task automatic test_random_codes();
    int target;
    int phase;
    target = sent_items + RANDOM_ITEMS;
    phase = 0;
    while (sent_items < target) begin
      case (phase % 4)
        0: set_gap(16'd1);
        1: set_gap(16'd2);
        2: set_gap(16'($urandom_range(3, 8)));
        default: set_gap(16'd12);
      endcase
      // one phase runs with no idling on either side
      src_idle_pct = (phase == 0) ? 0 : 25;
      snk_idle_pct = (phase == 0) ? 0 : 25;
      repeat (6) begin
        if (mdl_state != ST_IDLE && $urandom_range(9) != 0)
          send_item(OP_RESUME, LINES_W'($urandom), ADDR_W'($urandom));
        case ($urandom_range(9))
          0: repeat (10) send_noise();
          1: send_code($urandom_range(64, 75));
          default: send_code($urandom_range(1, 20));
        endcase
      end
      phase++;
    end
    src_idle_pct = 25;
    snk_idle_pct = 25;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed_sequence();
    test_buffer_overflow();
    test_output_backpressure();
    test_random_codes();
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_ir_pulse_width_recorder OK");
    end else begin
      $display("tb_ir_pulse_width_recorder NOT OK");
    end
    $finish;
  end

endmodule
